### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define ASSERT_CLKD(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/vlsd_pkg.sv
// ----------------------------------------------------------------------------
// vlsd_pkg
// Types and constants for the variable-length size decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package vlsd_pkg;

	// lead byte thresholds
	localparam logic [7:0] LEAD_TWO_BYTE = 8'd192;
	localparam logic [7:0] LEAD_BAD      = 8'd224;
	localparam logic [7:0] LEAD_FIVE     = 8'hff;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;

	// last byte index of a five-byte code
	localparam logic [2:0] PHASE_LAST = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} byte_word_t;

	typedef struct packed {
		logic [31:0] length_value;
		logic [1:0]  status;
	} size_word_t;

	// decoder result towards the output register
	typedef struct packed {
		logic       valid;
		size_word_t word;
	} dec_result_t;

endpackage

`default_nettype wire

### design/variable_length_size_decoder_top.sv
// ----------------------------------------------------------------------------
// variable_length_size_decoder_top
// Decodes back-to-back 1/2/5-byte length codes from a byte stream.
// ----------------------------------------------------------------------------
// The byte that completes a code passes the input register and the decoder; its result is held in the result register.
// Throughput: one byte per cycle unless the size channel stalls; the parser state updates with each byte taken.
// Input register and result register decouple the two channels.
// Reset: arst_n clears both valid flags and the parser state asynchronously.
`default_nettype none

module variable_length_size_decoder_top import vlsd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire byte_word_t byte_word,
	output logic            size_valid,
	input  wire logic       size_stall,
	output size_word_t      size_word
);

	logic        hold;
	logic        valid_s1;
	byte_word_t  word_s1;
	logic        fire;
	dec_result_t result;

	assign fire = valid_s1 && !hold;

	vlsd_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.hold       (hold),
		.valid_s1   (valid_s1),
		.word_s1    (word_s1)
	);

	vlsd_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.word_s1 (word_s1),
		.result  (result)
	);

	vlsd_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.result     (result),
		.size_stall (size_stall),
		.size_valid (size_valid),
		.size_word  (size_word),
		.hold       (hold)
	);

endmodule

`default_nettype wire

### design/vlsd_in_stage.sv
// ----------------------------------------------------------------------------
// vlsd_in_stage
// Input register for the byte channel; stalls only when the stored word
// cannot move on because the result register is held.
// ----------------------------------------------------------------------------
`default_nettype none

module vlsd_in_stage import vlsd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire byte_word_t byte_word,
	input  wire logic       hold,
	output logic            valid_s1,
	output byte_word_t      word_s1
);

	assign byte_stall = valid_s1 && hold;

	// load whenever the stored word is consumed or empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			word_s1 <= byte_word;
		end
	end

endmodule

`default_nettype wire

### design/vlsd_decode.sv
// ----------------------------------------------------------------------------
// vlsd_decode
// Length code parser: holds phase, lead byte and partial length, and turns
// one byte into at most one result word.
// ----------------------------------------------------------------------------
`default_nettype none

module vlsd_decode import vlsd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire byte_word_t word_s1,
	output dec_result_t     result
);

	logic [2:0]  phase_q;
	logic [7:0]  lead_q;
	logic [31:0] partial_q;

	logic [2:0]  phase_d;
	logic [7:0]  lead_d;
	logic [31:0] partial_d;
	logic [7:0]  b;
	logic        last;
	logic [31:0] shifted;
	logic [7:0]  lead_off;

	assign b        = word_s1.data_byte;
	assign last     = word_s1.buffer_end;
	assign shifted  = {partial_q[23:0], b};
	assign lead_off = lead_q - LEAD_TWO_BYTE;

	// next state and result
	always_comb begin
		phase_d   = phase_q;
		lead_d    = lead_q;
		partial_d = partial_q;
		result    = '0;
		if (phase_q == 3'd0) begin
			if (b < LEAD_TWO_BYTE) begin
				result.valid             = 1'b1;
				result.word.length_value = {24'd0, b};
				result.word.status       = ST_OK;
			end else if (b >= LEAD_BAD && b != LEAD_FIVE) begin
				result.valid       = 1'b1;
				result.word.status = ST_BAD_LEAD;
			end else if (last) begin
				result.valid       = 1'b1;
				result.word.status = ST_TRUNCATED;
			end else begin
				lead_d    = b;
				partial_d = '0;
				phase_d   = 3'd1;
			end
		end else if (lead_q != LEAD_FIVE) begin
			result.valid             = 1'b1;
			result.word.length_value = {16'd0, lead_off, 8'd0} + {24'd0, b}
				+ {24'd0, LEAD_TWO_BYTE};
			result.word.status       = ST_OK;
		end else if (phase_q >= PHASE_LAST) begin
			result.valid             = 1'b1;
			result.word.length_value = shifted;
			result.word.status       = ST_OK;
		end else if (last) begin
			result.valid       = 1'b1;
			result.word.status = ST_TRUNCATED;
		end else begin
			partial_d = shifted;
			phase_d   = phase_q + 3'd1;
		end
		// any result ends the code
		if (result.valid) begin
			phase_d   = 3'd0;
			partial_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 3'd0;
			lead_q    <= 8'd0;
			partial_q <= 32'd0;
		end else if (fire) begin
			phase_q   <= phase_d;
			lead_q    <= lead_d;
			partial_q <= partial_d;
		end
	end

endmodule

`default_nettype wire

### design/vlsd_out_reg.sv
// ----------------------------------------------------------------------------
// vlsd_out_reg
// Result register for the size channel; holds while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module vlsd_out_reg import vlsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        fire,
	input  wire dec_result_t result,
	input  wire logic        size_stall,
	output logic             size_valid,
	output size_word_t       size_word,
	output logic             hold
);

	assign hold = size_valid && size_stall;

	// reload whenever the held word is gone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_valid <= 1'b0;
		end else if (!hold) begin
			size_valid <= fire && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && fire && result.valid) begin
			size_word <= result.word;
		end
	end

endmodule

`default_nettype wire

### design/vlsd_checker.sv
// ----------------------------------------------------------------------------
// vlsd_checker
// Port-level checks on the size decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module vlsd_checker import vlsd_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       byte_valid,
	input wire logic       byte_stall,
	input wire byte_word_t byte_word,
	input wire logic       size_valid,
	input wire logic       size_stall,
	input wire size_word_t size_word
);

	logic byte_seen;

	assign byte_seen = byte_valid && (byte_word.data_byte != 8'd0 || byte_word.buffer_end);

	// no result word while in reset
	`ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !size_valid, "result word during reset")

	// status code stays in range
	`ASSERT_CLKD(a_status_range, size_valid |-> size_word.status != 2'd3, "bad status code")

	// an error word carries a zero length
	`ASSERT_CLKD(a_err_zero, (size_valid && size_word.status != ST_OK) |-> size_word.length_value == 32'd0, "error word has nonzero length")

	// a stalled result word holds
	`ASSERT_CLKD(a_out_hold, (size_valid && size_stall) |=> (size_valid && $stable(size_word)), "stalled word changed")

	// nonzero or end bytes never stall if result side is free
	`ASSERT_CLKD(a_no_idle_stall, (byte_seen && !size_stall) |-> !byte_stall, "byte stall without output stall")

endmodule

bind variable_length_size_decoder_top vlsd_checker u_vlsd_checker (.*);

`default_nettype wire
